// ===== rtl/kte_pkg.sv =====
package kte_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int NOW_BITS          = 32;
  localparam int KEYS              = 16;
  localparam int KEY_W             = 5;
  localparam int DEBOUNCE_W        = 16;
  localparam int CODE_W            = 8;
  localparam int COLUMN_W          = 4;
  localparam int COLUMNS           = 10;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

  // register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;

  localparam logic [CODE_W-1:0] CODE_NONE        = 8'd0;
  localparam logic [CODE_W-1:0] CODE_LOCK_FN     = 8'd5;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE   = 8'd8;
  localparam logic [CODE_W-1:0] CODE_LOCK_TOGGLE = 8'd19;
  localparam logic [CODE_W-1:0] CODE_STATE       = 8'd20;

  localparam logic [KEY_W-1:0] KEY_ZERO  = 5'd14;
  localparam logic [KEY_W-1:0] KEY_SHIFT = 5'd13;
  localparam logic [KEY_W-1:0] KEY_BACK  = 5'd15;

  typedef logic [CODE_W-1:0] char_t;

  typedef enum logic [2:0] {
    KC_NONE,
    KC_DIGIT,
    KC_PICK,
    KC_SHIFT,
    KC_BACK
  } key_class_t;

  typedef struct packed {
    logic             fire;
    logic [KEY_W-1:0] key;
  } press_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  lock_key;
    logic              shift_flag;
    logic              lock_flag;
    logic              waiting_flag;
  } result_t;

  // [pick group][shift][column]
  localparam char_t PICK_TABLE [4][2][COLUMNS] = '{
    '{ '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9"},
       '{".", "!", 8'd63, 8'd39, "-", "*", "/", "+", "&", " "} },
    '{ '{" ", "a", "d", "g", "j", "m", "p", "s", "v", "y"},
       '{",", "A", "D", "G", "J", "M", "P", "S", "V", "Y"} },
    '{ '{"^", "b", "e", "h", "k", "n", "q", "t", "w", "z"},
       '{":", "B", "E", "H", "K", "N", "Q", "T", "W", "Z"} },
    '{ '{"=", "c", "f", "i", "l", "o", "r", "u", "x", "("},
       '{"_", "C", "F", "I", "L", "O", "R", "U", "X", ")"} }
  };

  // highest pressed key wins, bit b is key b+1
  function automatic logic [KEY_W-1:0] top_key(input logic [KEYS-1:0] bits);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < KEYS; b++) begin
      if (bits[b]) k = KEY_W'(b + 1);
    end
    return k;
  endfunction

  function automatic key_class_t key_class(input logic [KEY_W-1:0] k);
    key_class_t c;
    case (k)
      5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd14: c = KC_DIGIT;
      5'd4, 5'd8, 5'd12, 5'd16: c = KC_PICK;
      KEY_SHIFT: c = KC_SHIFT;
      KEY_BACK:  c = KC_BACK;
      default:   c = KC_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [COLUMN_W-1:0] digit_column(input logic [KEY_W-1:0] k);
    logic [COLUMN_W-1:0] col;
    case (k)
      5'd1:    col = 4'd1;
      5'd2:    col = 4'd2;
      5'd3:    col = 4'd3;
      5'd5:    col = 4'd4;
      5'd6:    col = 4'd5;
      5'd7:    col = 4'd6;
      5'd9:    col = 4'd7;
      5'd10:   col = 4'd8;
      5'd11:   col = 4'd9;
      default: col = 4'd0;
    endcase
    return col;
  endfunction

endpackage

// ===== rtl/kte_sample_if.sv =====
interface kte_sample_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kte_pkg::KEYS-1:0]     pressed_keys;
  logic [kte_pkg::NOW_BITS-1:0] now_ms;
  logic                        lock_value;

  modport source (output valid, kind, pressed_keys, now_ms, lock_value, input ready);
  modport sink (input valid, kind, pressed_keys, now_ms, lock_value, output ready);
endinterface

// ===== rtl/kte_result_if.sv =====
interface kte_result_if;
  logic                      valid;
  logic                      ready;
  logic [kte_pkg::CODE_W-1:0] code;
  logic [kte_pkg::KEY_W-1:0]  lock_key;
  logic                      shift_flag;
  logic                      lock_flag;
  logic                      waiting_flag;

  modport source (output valid, code, lock_key, shift_flag, lock_flag, waiting_flag,
                  input ready);
  modport sink (input valid, code, lock_key, shift_flag, lock_flag, waiting_flag,
                output ready);
endinterface

// ===== rtl/kte_debounce.sv =====
module kte_debounce #(
  parameter int TIME_BITS = kte_pkg::TIME_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [kte_pkg::KEYS-1:0]       pressed_keys,
  input  logic [kte_pkg::NOW_BITS-1:0]   now_ms,
  input  logic [kte_pkg::DEBOUNCE_W-1:0] debounce_ms,
  output kte_pkg::press_t                press
);
  import kte_pkg::*;

  logic [KEY_W-1:0]     held_key;
  logic [TIME_BITS-1:0] change_time;
  logic                 press_latched;

  logic [KEY_W-1:0]     key;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 changed;
  logic                 expired;

  generate
    if (TIME_BITS <= NOW_BITS) begin : g_trunc
      assign now_t = now_ms[TIME_BITS-1:0];
    end else begin : g_ext
      assign now_t = {{(TIME_BITS-NOW_BITS){1'b0}}, now_ms};
    end
  endgenerate

  assign key     = top_key(pressed_keys);
  assign changed = key != held_key;
  assign elapsed = now_t - change_time;
  // a fresh change restarts the timer, so it cannot expire in the same beat
  assign expired = !changed && (elapsed > TIME_BITS'(debounce_ms));

  assign press.fire = expired && (key != '0) && !press_latched;
  assign press.key  = key;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_key      <= '0;
      change_time   <= '0;
      press_latched <= 1'b0;
    end else if (step) begin
      if (changed) begin
        held_key    <= key;
        change_time <= now_t;
      end
      if (expired) begin
        press_latched <= key != '0;
      end
    end
  end

endmodule

// ===== rtl/kte_decoder.sv =====
module kte_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             set_lock,
  input  logic             lock_value,
  input  kte_pkg::press_t  press,
  output kte_pkg::result_t result
);
  import kte_pkg::*;

  logic                shift_on, shift_on_next;
  logic                lock_on, lock_on_next;
  logic                awaiting_pick, awaiting_pick_next;
  logic [COLUMN_W-1:0] pending_column, pending_column_next;
  logic [KEY_W-1:0]    function_key, function_key_next;
  logic [CODE_W-1:0]   code;
  logic [1:0]          group;
  logic [KEY_W-1:0]    key_less;
  logic [COLUMN_W-1:0] col_idx;

  assign key_less = press.key - KEY_W'(1);
  assign group    = key_less[3:2];
  assign col_idx  = (pending_column < COLUMN_W'(COLUMNS)) ? pending_column : '0;

  always_comb begin
    shift_on_next       = shift_on;
    lock_on_next        = lock_on;
    awaiting_pick_next  = awaiting_pick;
    pending_column_next = pending_column;
    function_key_next   = function_key;
    code                = CODE_NONE;
    if (set_lock) begin
      lock_on_next = lock_value;
    end else if (press.fire) begin
      case (key_class(press.key))
        KC_DIGIT: begin
          if (awaiting_pick) begin
            awaiting_pick_next = 1'b0;
            code               = CODE_STATE;
          end else if (lock_on) begin
            function_key_next = press.key;
            code              = CODE_LOCK_FN;
          end else begin
            awaiting_pick_next  = 1'b1;
            pending_column_next = digit_column(press.key);
            code                = CODE_STATE;
          end
        end
        KC_PICK: begin
          if (awaiting_pick) begin
            code               = PICK_TABLE[group][shift_on][col_idx];
            shift_on_next      = 1'b0;
            awaiting_pick_next = 1'b0;
          end else if (lock_on) begin
            function_key_next = press.key;
            code              = CODE_LOCK_FN;
          end else begin
            code = CODE_STATE;
          end
        end
        KC_SHIFT: begin
          if (awaiting_pick) awaiting_pick_next = 1'b0;
          else shift_on_next = !shift_on;
          code = CODE_STATE;
        end
        KC_BACK: begin
          if (awaiting_pick) begin
            awaiting_pick_next = 1'b0;
            code               = CODE_STATE;
          end else if (shift_on) begin
            lock_on_next = !lock_on;
            code         = CODE_LOCK_TOGGLE;
          end else begin
            code = CODE_BACKSPACE;
          end
        end
        default: code = CODE_NONE;
      endcase
    end
  end

  assign result.code         = code;
  assign result.lock_key     = function_key_next;
  assign result.shift_flag   = shift_on_next;
  assign result.lock_flag    = lock_on_next;
  assign result.waiting_flag = awaiting_pick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_on       <= 1'b0;
      lock_on        <= 1'b0;
      awaiting_pick  <= 1'b0;
      pending_column <= '0;
      function_key   <= '0;
    end else if (step) begin
      shift_on       <= shift_on_next;
      lock_on        <= lock_on_next;
      awaiting_pick  <= awaiting_pick_next;
      pending_column <= pending_column_next;
      function_key   <= function_key_next;
    end
  end

endmodule

// ===== rtl/keypad_text_entry.sv =====
// Keypad text entry.
// samples: one beat per scan sample (kind 0: key bitmap and millisecond time)
// or per lock write (kind 1: lock flag from lock_value). results: exactly one
// beat per sample beat, in order, carrying the decoded code (0 when nothing
// new was pressed) and the shift, lock and pick-pending flags after the item.
// An accepted sample passes through the input register, then through the
// debounce and decode logic into the result register. Throughput is one item
// per cycle while the receiver does not stall. When the receiver stalls, the
// result register holds its beat and the input register can take one more
// sample before samples.ready drops; nothing is dropped. Synchronous reset
// clears the debounce and text-entry state, both stage valids, and loads
// debounce_ms with 20. The APB port holds debounce_ms at byte address 0; the
// user must write it only while the block is idle, which the block itself
// does not enforce. pready is always high.
module keypad_text_entry #(
  parameter int TIME_BITS = kte_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  kte_sample_if.sink                      samples,
  kte_result_if.source                    results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kte_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kte_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kte_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import kte_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_ms;

  logic                s1_valid;
  logic                s1_kind;
  logic [KEYS-1:0]     s1_keys;
  logic [NOW_BITS-1:0] s1_now;
  logic                s1_lock_value;

  logic    out_valid;
  result_t out_data;

  logic    out_free;
  logic    step;
  press_t  press;
  result_t result;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEBOUNCE) ? APB_DATA_W'(debounce_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEBOUNCE) begin
      debounce_ms <= pwdata[DEBOUNCE_W-1:0];
    end
  end

  assign out_free      = !out_valid || results.ready;
  assign step          = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_kind       <= samples.kind;
      s1_keys       <= samples.pressed_keys;
      s1_now        <= samples.now_ms;
      s1_lock_value <= samples.lock_value;
    end
  end

  kte_debounce #(
    .TIME_BITS(TIME_BITS)
  ) u_debounce (
    .clk          (clk),
    .rst          (rst),
    .step         (step && !s1_kind),
    .pressed_keys (s1_keys),
    .now_ms       (s1_now),
    .debounce_ms  (debounce_ms),
    .press        (press)
  );

  kte_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .set_lock   (s1_kind),
    .lock_value (s1_lock_value),
    .press      (press),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  assign results.valid        = out_valid;
  assign results.code         = out_data.code;
  assign results.lock_key     = out_data.lock_key;
  assign results.shift_flag   = out_data.shift_flag;
  assign results.lock_flag    = out_data.lock_flag;
  assign results.waiting_flag = out_data.waiting_flag;

endmodule

// ===== tb/kte_entry_checker.sv =====
`timescale 1ns / 1ps

module kte_entry_checker (
  input  logic                          clk,
  input  logic                          rst,
  kte_sample_if                         samples,
  kte_result_if                         results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [kte_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kte_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [kte_pkg::APB_DATA_W-1:0] prdata,
  output int                            errors,
  output int                            backlog
);
  import kte_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [KEY_W-1:0]      held_key;
  logic [KEY_W-1:0]      fn_key;
  logic [NOW_BITS-1:0]   stable_since;
  logic                  latched;
  logic                  shift_on;
  logic                  lock_on;
  logic                  picking;
  logic [COLUMN_W-1:0]   column;
  result_t               pending_entries[$];

  // ten characters per row, leftmost is column 0
  function automatic logic [79:0] char_row(input logic [1:0] group, input logic shifted);
    case ({group, shifted})
      3'b000:  return "0123456789";
      3'b001:  return {".!?", 8'd39, "-*/+& "};
      3'b010:  return " adgjmpsvy";
      3'b011:  return ",ADGJMPSVY";
      3'b100:  return "^behknqtwz";
      3'b101:  return ":BEHKNQTWZ";
      3'b110:  return "=cfilorux(";
      default: return "_CFILORUX)";
    endcase
  endfunction

  function automatic logic [COLUMN_W-1:0] column_of(input logic [KEY_W-1:0] k);
    case (k)
      5'd1, 5'd2, 5'd3:   return COLUMN_W'(k);
      5'd5, 5'd6, 5'd7:   return COLUMN_W'(k - 5'd1);
      5'd9, 5'd10, 5'd11: return COLUMN_W'(k - 5'd2);
      default:            return '0;
    endcase
  endfunction

  task automatic decode_press(input logic [KEY_W-1:0] k, output logic [CODE_W-1:0] c);
    logic [79:0] row;
    logic [1:0]  group;
    c = CODE_STATE;
    case (k)
      5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, KEY_ZERO: begin
        if (picking) begin
          picking = 1'b0;
        end else if (lock_on) begin
          fn_key = k;
          c = CODE_LOCK_FN;
        end else begin
          picking = 1'b1;
          column = column_of(k);
        end
      end
      5'd4, 5'd8, 5'd12, 5'd16: begin
        if (picking) begin
          group = 2'(k[4:2] - 3'd1);
          row = char_row(group, shift_on);
          c = row[8 * (9 - column) +: 8];
          shift_on = 1'b0;
          picking = 1'b0;
        end else if (lock_on) begin
          fn_key = k;
          c = CODE_LOCK_FN;
        end
      end
      KEY_SHIFT: begin
        if (picking) picking = 1'b0;
        else shift_on = !shift_on;
      end
      KEY_BACK: begin
        if (picking) begin
          picking = 1'b0;
        end else if (shift_on) begin
          lock_on = !lock_on;
          c = CODE_LOCK_TOGGLE;
        end else begin
          c = CODE_BACKSPACE;
        end
      end
      default: c = CODE_NONE;
    endcase
  endtask

  task automatic predict_entry(input logic kind, input logic [KEYS-1:0] keys,
                               input logic [NOW_BITS-1:0] now, input logic lock_value,
                               output result_t r);
    logic [KEY_W-1:0]    k;
    logic [CODE_W-1:0]   c;
    logic [NOW_BITS-1:0] age;
    c = CODE_NONE;
    if (kind) begin
      lock_on = lock_value;
    end else begin
      k = '0;
      for (int b = 0; b < KEYS; b++) begin
        if (keys[b]) k = KEY_W'(b + 1);
      end
      if (k != held_key) begin
        held_key = k;
        stable_since = now;
      end
      age = now - stable_since;
      if (age > NOW_BITS'(debounce_ms)) begin
        if (k != '0 && !latched) begin
          latched = 1'b1;
          decode_press(k, c);
        end
        if (k == '0) latched = 1'b0;
      end
    end
    r.code = c;
    r.lock_key = fn_key;
    r.shift_flag = shift_on;
    r.lock_flag = lock_on;
    r.waiting_flag = picking;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      debounce_ms = DEBOUNCE_RESET;
      held_key = '0;
      fn_key = '0;
      stable_since = '0;
      latched = 1'b0;
      shift_on = 1'b0;
      lock_on = 1'b0;
      picking = 1'b0;
      column = '0;
      pending_entries.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_DEBOUNCE) begin
        if (pwrite) debounce_ms = pwdata[DEBOUNCE_W-1:0];
        else if (prdata[DEBOUNCE_W-1:0] !== debounce_ms)
          note_mismatch("debounce_ms readback", 32'(debounce_ms),
                        32'(prdata[DEBOUNCE_W-1:0]));
      end
      if (samples.valid && samples.ready) begin
        predict_entry(samples.kind, samples.pressed_keys, samples.now_ms,
                      samples.lock_value, want);
        pending_entries.push_back(want);
      end
      if (results.valid && results.ready) begin
        if (pending_entries.size() == 0) begin
          note_mismatch("result beat with nothing pending, code", 32'd0, 32'(results.code));
        end else begin
          want = pending_entries.pop_front();
          if (results.code !== want.code)
            note_mismatch("code", 32'(want.code), 32'(results.code));
          if (results.lock_key !== want.lock_key)
            note_mismatch("lock_key", 32'(want.lock_key), 32'(results.lock_key));
          if (results.shift_flag !== want.shift_flag)
            note_mismatch("shift_flag", 32'(want.shift_flag), 32'(results.shift_flag));
          if (results.lock_flag !== want.lock_flag)
            note_mismatch("lock_flag", 32'(want.lock_flag), 32'(results.lock_flag));
          if (results.waiting_flag !== want.waiting_flag)
            note_mismatch("waiting_flag", 32'(want.waiting_flag),
                          32'(results.waiting_flag));
        end
      end
    end
    backlog = pending_entries.size();
  end

endmodule

// ===== tb/tb_keypad_text_entry.sv =====
`timescale 1ns / 1ps

module tb_keypad_text_entry;
  import kte_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 170;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  int                    errors;
  int                    backlog;
  int                    send_idle;
  int                    recv_stall;
  int                    idle_cycles;
  int                    sent;
  int                    target;
  int                    halfway;
  logic [NOW_BITS-1:0]   clock_ms;
  logic [DEBOUNCE_W-1:0] hold_ms;
  logic [DEBOUNCE_W-1:0] setting;

  kte_sample_if samples();
  kte_result_if results();

  keypad_text_entry uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kte_entry_checker entry_check (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .errors  (errors),
    .backlog (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    results.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // any accepted beat or bus access resets the hang counter
  always @(posedge clk) begin
    if ((samples.valid && samples.ready) || (results.valid && results.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL keypad_text_entry");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic kind, input logic [KEYS-1:0] keys,
                           input logic [NOW_BITS-1:0] now, input logic lock_value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.kind <= kind;
    samples.pressed_keys <= keys;
    samples.now_ms <= now;
    samples.lock_value <= lock_value;
    do @(posedge clk); while (samples.ready !== 1'b1);
    sent++;
  endtask

  task automatic scan(input logic [KEYS-1:0] keys, input logic [NOW_BITS-1:0] step);
    clock_ms = clock_ms + step;
    send_item(1'b0, keys, clock_ms, 1'($urandom));
  endtask

  function automatic logic [NOW_BITS-1:0] past_debounce();
    return NOW_BITS'(hold_ms) + 32'd1 + NOW_BITS'($urandom_range(0, 20));
  endfunction

  function automatic logic [NOW_BITS-1:0] within_debounce();
    return NOW_BITS'($urandom_range(0, int'(hold_ms)));
  endfunction

  // top bit picks the key, lower bits are random extra presses
  function automatic logic [KEYS-1:0] key_mask(input int k);
    logic [KEYS-1:0] top;
    top = KEYS'(1) << (k - 1);
    return top | (KEYS'($urandom) & (top - KEYS'(1)));
  endfunction

  task automatic tap(input logic [KEYS-1:0] keys);
    scan(keys, past_debounce());
    scan(keys, past_debounce());
    scan('0, past_debounce());
    scan('0, past_debounce());
  endtask

  task automatic random_event();
    int              pick;
    int              k;
    logic [KEYS-1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_item(1'b1, KEYS'($urandom), $urandom, 1'($urandom));
    end else if (pick < 25) begin
      if ($urandom_range(0, 3) == 0) scan(KEYS'($urandom), $urandom);
      else scan(KEYS'($urandom), NOW_BITS'($urandom_range(0, 2 * int'(hold_ms) + 2)));
    end else begin
      k = $urandom_range(1, 16);
      m = key_mask(k);
      if ($urandom_range(0, 3) == 0) scan(KEYS'($urandom), within_debounce());
      scan(m, within_debounce());
      if ($urandom_range(0, 3) == 0) begin
        // lands exactly on the debounce time, then one past it
        scan(key_mask(k), NOW_BITS'(hold_ms));
        scan(key_mask(k), 32'd1);
      end else begin
        scan(key_mask(k), past_debounce());
      end
      if ($urandom_range(0, 3) == 0) scan(key_mask(k), within_debounce());
      // sometimes the key is never released
      if ($urandom_range(0, 4) != 0) begin
        scan('0, within_debounce());
        if ($urandom_range(0, 4) == 0) scan(m, within_debounce());
        scan('0, past_debounce());
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [DEBOUNCE_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {REG_DEBOUNCE, 2'b00};
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples.valid = 1'b0;
    samples.kind = 1'b0;
    samples.pressed_keys = '0;
    samples.now_ms = '0;
    samples.lock_value = 1'b0;
    results.ready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    idle_cycles = 0;
    sent = 0;
    hold_ms = DEBOUNCE_RESET;
    clock_ms = 32'hFFFF_FFC0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset debounce, time wraps during the first presses
    tap(16'h2000);
    tap(16'h00FF);
    tap(16'h4000);
    tap(16'h1000);
    tap(16'h4000);
    tap(16'hFFFF);
    send_item(1'b1, 16'hFFFF, 32'h0000_0000, 1'b0);
    send_item(1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0:       setting = 16'h0000;
        1:       setting = 16'hFFFF;
        2:       setting = DEBOUNCE_W'($urandom_range(1, 40));
        default: setting = DEBOUNCE_W'($urandom);
      endcase
      apb_access(1'b1, setting);
      apb_access(1'b0, '0);
      hold_ms = setting;
      @(posedge clk);
      case (p)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 75;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 75;
        end
        default: begin
          send_idle = 21;
          recv_stall = 21;
        end
      endcase
      target = sent + ITEMS_PER_PHASE;
      halfway = sent + ITEMS_PER_PHASE / 2;
      while (sent < target) begin
        random_event();
        // hold off once per phase until all results are back
        if (sent >= halfway && halfway != 0) begin
          drain();
          halfway = 0;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && backlog == 0) begin
      $display("PASS keypad_text_entry");
    end else begin
      $display("FAIL keypad_text_entry");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kte_pkg.sv
rtl/kte_sample_if.sv
rtl/kte_result_if.sv
rtl/kte_debounce.sv
rtl/kte_decoder.sv
rtl/keypad_text_entry.sv
tb/kte_entry_checker.sv
tb/tb_keypad_text_entry.sv
